// ===== hw/rtl/vnf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the value noise fBm core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vnf_pkg;

    localparam int VNF_MAX_OCTAVES = 8;

    localparam logic [31:0] GOLD_MUL = 32'h9E3779B9;
    localparam logic [31:0] MIX_MUL1 = 32'h85EBCA6B;
    localparam logic [31:0] MIX_MUL2 = 32'hC2B2AE35;

    localparam logic [1:0] REG_NOISE_SEED     = 2'd0;
    localparam logic [1:0] REG_BASE_FREQUENCY = 2'd1;
    localparam logic [1:0] REG_OCTAVE_COUNT   = 2'd2;

    localparam logic [31:0] SEED_RESET      = 32'd0;
    localparam logic [31:0] FREQUENCY_RESET = 32'd4194;
    localparam logic [3:0]  OCTAVES_RESET   = 4'd3;

    typedef struct packed {
        logic               valid;
        logic signed [63:0] px;
        logic signed [63:0] pz;
        logic signed [33:0] sum;
    } vnf_lane_t;

    function automatic logic [16:0] recip_lookup(input logic [4:0] n);
        logic [16:0] r;
        case (n)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd43691;
            5'd3:    r = 17'd37449;
            5'd4:    r = 17'd34953;
            5'd5:    r = 17'd33825;
            5'd6:    r = 17'd33288;
            5'd7:    r = 17'd33026;
            5'd8:    r = 17'd32897;
            5'd9:    r = 17'd32832;
            5'd10:   r = 17'd32800;
            5'd11:   r = 17'd32784;
            5'd12:   r = 17'd32776;
            5'd13:   r = 17'd32772;
            5'd14:   r = 17'd32770;
            5'd15:   r = 17'd32769;
            5'd16:   r = 17'd32769;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] fade_mix(input logic [15:0] t5, input logic [15:0] t4,
                                             input logic [15:0] t3);
        logic [19:0] pos;
        logic [19:0] neg;
        logic [19:0] diff;
        logic [16:0] r;
        pos  = 20'(t5) * 20'd6 + 20'(t3) * 20'd10;
        neg  = 20'(t4) * 20'd15;
        diff = pos - neg;
        if (pos <= neg) begin
            r = 17'd0;
        end else if (diff > 20'd65536) begin
            r = 17'd65536;
        end else begin
            r = diff[16:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] lerp31(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [16:0] u);
        logic signed [32:0] diff;
        logic signed [50:0] prod;
        logic signed [34:0] acc;
        diff = 33'(b) - 33'(a);
        prod = 51'(diff) * $signed({1'b0, u});
        acc  = 35'(a) + 35'(prod >>> 16);
        return acc[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vnf_octave_cell.sv =====
// One octave cell of the fBm chain: lattice split, corner hashing, fade and blend.
// Adds its weighted octave to the running sum; uses vnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vnf_octave_cell
    import vnf_pkg::*;
#(
    parameter int OCT = 0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic [31:0] noise_seed,
    input  wire logic [3:0]  octave_count,
    input  wire vnf_lane_t   lane_i,
    output vnf_lane_t        lane_o
);

    localparam int          SHIFT    = 40 - OCT;
    localparam logic [3:0]  OCT_CODE = 4'(OCT);
    localparam logic [31:0] SEED_OFS = 32'(OCT);

    vnf_lane_t          lane_reg [8];
    vnf_lane_t          out_reg;

    logic signed [63:0] shifted  [2];
    logic [31:0]        ci_reg   [2];
    logic [15:0]        t_a_reg  [2];

    logic [31:0]        m_next   [2][2];
    logic [31:0]        m_reg    [2][2];
    logic [15:0]        t2_b_reg [2];
    logic [15:0]        t_b_reg  [2];

    logic [31:0]        bx_next  [2];
    logic [31:0]        bx_reg   [2];
    logic [31:0]        az_reg   [2];
    logic [15:0]        t3_c_reg [2];
    logic [15:0]        t_c_reg  [2];

    logic [31:0]        h_next   [2][2];
    logic [31:0]        h_reg    [2][2];
    logic [15:0]        t4_d_reg [2];
    logic [15:0]        t3_d_reg [2];
    logic [15:0]        t_d_reg  [2];

    logic signed [31:0] corner_next [2][2];
    logic signed [31:0] corner_reg  [2][2];
    logic [15:0]        t5_e_reg [2];
    logic [15:0]        t4_e_reg [2];
    logic [15:0]        t3_e_reg [2];

    logic [16:0]        u_reg    [2];
    logic signed [31:0] corner_f_reg [2][2];

    logic signed [31:0] n_reg    [2];
    logic [16:0]        uz_reg;
    logic signed [31:0] v_reg;
    logic signed [33:0] contrib;

    always_comb begin
        logic [31:0] g;
        logic [31:0] x;
        logic [31:0] hv;
        shifted[0] = lane_i.px >>> SHIFT;
        shifted[1] = lane_i.pz >>> SHIFT;
        for (int k = 0; k < 2; k++) begin
            for (int o = 0; o < 2; o++) begin
                m_next[k][o] = (ci_reg[k] + 32'(o)) * ((k == 0) ? GOLD_MUL : MIX_MUL2);
            end
        end
        for (int o = 0; o < 2; o++) begin
            g          = noise_seed + SEED_OFS;
            g          = g ^ m_reg[0][o];
            bx_next[o] = (g ^ (g >> 15)) * MIX_MUL1;
        end
        for (int ox = 0; ox < 2; ox++) begin
            for (int oz = 0; oz < 2; oz++) begin
                x               = bx_reg[ox] ^ az_reg[oz];
                h_next[ox][oz]  = (x ^ (x >> 13)) * MIX_MUL2;
                hv              = h_reg[ox][oz] ^ (h_reg[ox][oz] >> 16);
                corner_next[ox][oz] = $signed({~hv[31], hv[30:0]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                ci_reg[k]   <= shifted[k][31:0];
                t_a_reg[k]  <= (k == 0) ? lane_i.px[SHIFT-1 -: 16] : lane_i.pz[SHIFT-1 -: 16];

                t2_b_reg[k] <= 16'((32'(t_a_reg[k]) * 32'(t_a_reg[k])) >> 16);
                t_b_reg[k]  <= t_a_reg[k];

                t3_c_reg[k] <= 16'((32'(t2_b_reg[k]) * 32'(t_b_reg[k])) >> 16);
                t_c_reg[k]  <= t_b_reg[k];

                t4_d_reg[k] <= 16'((32'(t3_c_reg[k]) * 32'(t_c_reg[k])) >> 16);
                t3_d_reg[k] <= t3_c_reg[k];
                t_d_reg[k]  <= t_c_reg[k];

                t5_e_reg[k] <= 16'((32'(t4_d_reg[k]) * 32'(t_d_reg[k])) >> 16);
                t4_e_reg[k] <= t4_d_reg[k];
                t3_e_reg[k] <= t3_d_reg[k];

                u_reg[k]    <= fade_mix(t5_e_reg[k], t4_e_reg[k], t3_e_reg[k]);

                bx_reg[k]   <= bx_next[k];
                az_reg[k]   <= m_reg[1][k];
                for (int o = 0; o < 2; o++) begin
                    m_reg[k][o]        <= m_next[k][o];
                    h_reg[k][o]        <= h_next[k][o];
                    corner_reg[k][o]   <= corner_next[k][o];
                    corner_f_reg[k][o] <= corner_reg[k][o];
                end
                n_reg[k]    <= lerp31(corner_f_reg[0][k], corner_f_reg[1][k], u_reg[0]);
            end
            uz_reg <= u_reg[1];
            v_reg  <= lerp31(n_reg[0], n_reg[1], uz_reg);
        end
    end

    assign contrib = (octave_count > OCT_CODE) ? (34'(v_reg) >>> OCT) : 34'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 8; j++) begin
                lane_reg[j].valid <= 1'b0;
            end
            out_reg.valid <= 1'b0;
        end else if (en) begin
            lane_reg[0] <= lane_i;
            for (int j = 1; j < 8; j++) begin
                lane_reg[j] <= lane_reg[j-1];
            end
            out_reg.valid <= lane_reg[7].valid;
            out_reg.px    <= lane_reg[7].px;
            out_reg.pz    <= lane_reg[7].pz;
            out_reg.sum   <= lane_reg[7].sum + contrib;
        end
    end

    assign lane_o = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vnf_norm.sv =====
// Normalization and output register: scales the octave sum by the reciprocal
// of the total amplitude, rounds and saturates to Q1.15. Uses vnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vnf_norm
    import vnf_pkg::*;
#(
    parameter int MAX_OCTAVES = VNF_MAX_OCTAVES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic [3:0]  octave_count,
    input  wire vnf_lane_t   lane_i,
    output logic             m_valid,
    output logic [15:0]      m_noise_value
);

    localparam logic [4:0] MAX_N = 5'(MAX_OCTAVES);

    logic [4:0]         n_eff;
    logic [16:0]        recip;
    logic               valid1_reg;
    logic signed [50:0] prod_reg;
    logic signed [51:0] rounded;
    logic signed [19:0] scaled;
    logic [15:0]        sat_value;
    logic               out_valid_reg;
    logic [15:0]        out_value_reg;

    assign n_eff   = ({1'b0, octave_count} > MAX_N) ? MAX_N : {1'b0, octave_count};
    assign recip   = recip_lookup(n_eff);
    assign rounded = 52'(prod_reg) + 52'sd2147483648;
    assign scaled  = 20'(rounded >>> 32);

    always_comb begin
        if (scaled > 20'sd32767) begin
            sat_value = 16'h7FFF;
        end else if (scaled < -20'sd32768) begin
            sat_value = 16'h8000;
        end else begin
            sat_value = scaled[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= 51'(lane_i.sum) * $signed({1'b0, recip});
            out_value_reg <= sat_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid1_reg    <= lane_i.valid;
            out_valid_reg <= valid1_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_noise_value = out_value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/value_noise_fbm_core.sv =====
// Top level of the 2D value noise fBm core: configuration registers, coordinate
// scaling, the chain of octave cells and the normalizing output stage.
// Depends on vnf_pkg, vnf_octave_cell and vnf_norm.
//
//  Channel   Ports                                   Direction
//  request   s_valid s_ready s_x_coord s_z_coord     in
//  result    m_valid m_ready m_noise_value           out
//  config    cfg_we cfg_addr cfg_wdata               in
//
// One request is taken per cycle while the output is not stalled; a result passes
// through the input register, the nine register stages of each octave cell
// and the two stages of the normalizing output.
// All octave cells run whatever the octave count; unused ones add nothing.
// When a result is held by m_ready low, the whole chain halts and s_ready drops.
// Reset is synchronous and active low; it restores the configuration registers
// and clears only the valid flags of the data path.
`timescale 1ns / 1ps
`default_nettype none

module value_noise_fbm_core
    import vnf_pkg::*;
#(
    parameter int MAX_OCTAVES = VNF_MAX_OCTAVES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_x_coord,
    input  wire logic signed [31:0] s_z_coord,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_noise_value,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata
);

    logic [31:0]        noise_seed_reg;
    logic [31:0]        base_frequency_reg;
    logic [3:0]         octave_count_reg;

    logic               en;
    logic signed [64:0] prod_x;
    logic signed [64:0] prod_z;
    vnf_lane_t          front_reg;
    vnf_lane_t          chain [MAX_OCTAVES+1];
    logic [15:0]        noise_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg     <= SEED_RESET;
            base_frequency_reg <= FREQUENCY_RESET;
            octave_count_reg   <= OCTAVES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NOISE_SEED:     noise_seed_reg     <= cfg_wdata;
                REG_BASE_FREQUENCY: base_frequency_reg <= cfg_wdata;
                REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign prod_x = s_x_coord * $signed({1'b0, base_frequency_reg});
    assign prod_z = s_z_coord * $signed({1'b0, base_frequency_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (en) begin
            front_reg.valid <= s_valid;
            front_reg.px    <= prod_x[63:0];
            front_reg.pz    <= prod_z[63:0];
            front_reg.sum   <= 34'sd0;
        end
    end

    assign chain[0] = front_reg;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
        vnf_octave_cell #(
            .OCT(g)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .noise_seed  (noise_seed_reg),
            .octave_count(octave_count_reg),
            .lane_i      (chain[g]),
            .lane_o      (chain[g+1])
        );
    end

    vnf_norm #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_norm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .octave_count (octave_count_reg),
        .lane_i       (chain[MAX_OCTAVES]),
        .m_valid      (m_valid),
        .m_noise_value(noise_raw)
    );

    assign m_noise_value = $signed(noise_raw);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid survived reset");

    a_stall_freezes_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(chain[MAX_OCTAVES].sum))
        else $error("octave chain moved while the output was stalled");

endmodule

`default_nettype wire

// ===== sim/value_noise_fbm_core_tb.sv =====
// Self-checking testbench for value_noise_fbm_core: drives coordinate requests,
// predicts each fBm result in SystemVerilog and compares it with the output.
// Depends on vnf_pkg and the value_noise_fbm_core RTL.
`timescale 1ns / 1ps

class noise_scoreboard;
    logic [31:0]        seed;
    logic [31:0]        freq;
    logic [3:0]         octaves;
    logic signed [15:0] pending[$];
    int                 errors;

    function new();
        seed = vnf_pkg::SEED_RESET;
        freq = vnf_pkg::FREQUENCY_RESET;
        octaves = vnf_pkg::OCTAVES_RESET;
        errors = 0;
    endfunction

    function logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cz, logic [31:0] s);
        logic [31:0] h;
        h = s ^ (cx * vnf_pkg::GOLD_MUL);
        h = (h ^ (h >> 15)) * vnf_pkg::MIX_MUL1;
        h = h ^ (cz * vnf_pkg::MIX_MUL2);
        h = (h ^ (h >> 13)) * vnf_pkg::MIX_MUL2;
        return h ^ (h >> 16);
    endfunction

    function longint corner(logic [31:0] cx, logic [31:0] cz, logic [31:0] s);
        return longint'({32'd0, cell_hash(cx, cz, s)}) - 64'sd2147483648;
    endfunction

    function longint fade(longint t);
        longint t2, t3, t4, t5, f;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        t4 = (t3 * t) >>> 16;
        t5 = (t4 * t) >>> 16;
        f = 6 * t5 - 15 * t4 + 10 * t3;
        if (f < 0) f = 0;
        if (f > 65536) f = 65536;
        return f;
    endfunction

    function longint blend(longint a, longint b, longint u);
        return a + ((b - a) * u >>> 16);
    endfunction

    function logic signed [15:0] predict(logic signed [31:0] x, logic signed [31:0] z);
        longint px, pz, ux, uz, n0, n1, v, total, r;
        logic [31:0] ix, iz, s;
        int n, sh;
        px = longint'(x) * longint'({32'd0, freq});
        pz = longint'(z) * longint'({32'd0, freq});
        n = (octaves > vnf_pkg::VNF_MAX_OCTAVES) ? vnf_pkg::VNF_MAX_OCTAVES : octaves;
        total = 0;
        for (int i = 0; i < n; i++) begin
            sh = 40 - i;
            ix = 32'(px >>> sh);
            iz = 32'(pz >>> sh);
            ux = fade((px >> (sh - 16)) & 64'hFFFF);
            uz = fade((pz >> (sh - 16)) & 64'hFFFF);
            s = seed + 32'(i);
            n0 = blend(corner(ix, iz, s), corner(ix + 1, iz, s), ux);
            n1 = blend(corner(ix, iz + 1, s), corner(ix + 1, iz + 1, s), ux);
            v = blend(n0, n1, uz);
            total += v >>> i;
        end
        r = (total * longint'(vnf_pkg::recip_lookup(5'(n))) + 64'sd2147483648) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function void note_request(logic signed [31:0] x, logic signed [31:0] z);
        pending.push_back(predict(x, z));
    endfunction

    task check_result(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", got));
            return;
        end
        want = pending.pop_front();
        if (got !== want)
            report_mismatch($sformatf("noise_value got %0d want %0d", got, want));
    endtask

    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask
endclass

module value_noise_fbm_core_tb;
    import vnf_pkg::*;

    localparam int LATENCY = 2 + 9 * VNF_MAX_OCTAVES;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_x_coord = '0;
    logic signed [31:0] s_z_coord = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_noise_value;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [31:0]        cfg_wdata = '0;

    noise_scoreboard board = new();
    int  idle_cycles = 0;
    bit  stall_free = 1'b0;
    bit  sink_free = 1'b0;

    always #5 aclk = ~aclk;

    value_noise_fbm_core dut (.*);

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (s_valid && s_ready) board.note_request(s_x_coord, s_z_coord);
            if (m_valid && m_ready) board.check_result(m_noise_value);
        end
    end

    initial begin : result_sink
        int gap;
        forever begin
            @(negedge aclk);
            if (!aresetn) continue;
            gap = sink_free ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NOISE_SEED:     board.seed = value;
            REG_BASE_FREQUENCY: board.freq = value;
            REG_OCTAVE_COUNT:   board.octaves = value[3:0];
            default: ;
        endcase
    endtask

    task automatic send_request(logic signed [31:0] x, logic signed [31:0] z);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_x_coord <= x;
        s_z_coord <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 65536 * 64)) - 65536 * 32);
        endcase
    endfunction

    initial begin : watchdog
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] freqs[6];
        logic [31:0] corners[6];
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        corners = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000, 32'h00008000};
        for (int i = 0; i < 6; i++) send_request(corners[i], corners[5 - i]);
        drain();

        write_reg(REG_BASE_FREQUENCY, 32'd0);
        write_reg(REG_NOISE_SEED, 32'hFFFFFFFF);
        write_reg(REG_OCTAVE_COUNT, 4'd8);
        for (int i = 0; i < 4; i++) send_request(corners[i], corners[i + 1]);
        drain();
        write_reg(REG_OCTAVE_COUNT, 4'd0);
        send_request(32'h12345678, 32'h87654321);
        send_request(32'h80000000, 32'h7FFFFFFF);
        drain();
        write_reg(REG_OCTAVE_COUNT, 4'd15);
        write_reg(REG_BASE_FREQUENCY, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++) send_request(corners[5 - i], corners[i]);
        drain();
        write_reg(REG_OCTAVE_COUNT, 4'd1);
        write_reg(REG_BASE_FREQUENCY, 32'd1);
        send_request(32'h7FFFFFFF, 32'h80000000);
        send_request(32'h00000001, 32'hFFFFFFFE);
        drain();

        freqs = '{32'd4194, 32'h01000000, 32'hFFFFFFFF, 32'd1, 32'h00100000, 32'h0};
        for (int phase = 0; phase < 16; phase++) begin
            write_reg(REG_NOISE_SEED, $urandom());
            write_reg(REG_BASE_FREQUENCY, (phase % 2) ? $urandom() : freqs[phase % 6]);
            write_reg(REG_OCTAVE_COUNT, (phase < 9) ? 4'(phase) : 4'($urandom_range(0, 15)));
            stall_free = (phase % 5 == 3);
            sink_free = (phase % 7 == 2);
            for (int k = 0; k < 100; k++) send_request(rand_coord(), rand_coord());
            drain();
        end

        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/vnf_pkg.sv
hw/rtl/vnf_octave_cell.sv
hw/rtl/vnf_norm.sv
hw/rtl/value_noise_fbm_core.sv
sim/value_noise_fbm_core_tb.sv
